// File: hdl/x86a_pkg.sv
// ----------------------------------------------------------------------------
// x86a_pkg
// Operation codes, flag positions, pipeline types and flag helpers for the
// 16-bit x86 ALU.
// ----------------------------------------------------------------------------
package x86a_pkg;

    localparam logic [4:0] F_ADD  = 5'd0;
    localparam logic [4:0] F_ADC  = 5'd1;
    localparam logic [4:0] F_SUB  = 5'd2;
    localparam logic [4:0] F_SBB  = 5'd3;
    localparam logic [4:0] F_CMP  = 5'd4;
    localparam logic [4:0] F_AND  = 5'd5;
    localparam logic [4:0] F_OR   = 5'd6;
    localparam logic [4:0] F_XOR  = 5'd7;
    localparam logic [4:0] F_TEST = 5'd8;
    localparam logic [4:0] F_INC  = 5'd9;
    localparam logic [4:0] F_DEC  = 5'd10;
    localparam logic [4:0] F_NEG  = 5'd11;
    localparam logic [4:0] F_NOT  = 5'd12;
    localparam logic [4:0] F_SHL  = 5'd13;
    localparam logic [4:0] F_SHR  = 5'd14;
    localparam logic [4:0] F_SAR  = 5'd15;
    localparam logic [4:0] F_ROL  = 5'd16;
    localparam logic [4:0] F_ROR  = 5'd17;
    localparam logic [4:0] F_RCL  = 5'd18;
    localparam logic [4:0] F_RCR  = 5'd19;
    localparam logic [4:0] F_MUL  = 5'd20;
    localparam logic [4:0] F_IMUL = 5'd21;
    localparam logic [4:0] F_DIV  = 5'd22;
    localparam logic [4:0] F_IDIV = 5'd23;
    localparam logic [4:0] F_AAA  = 5'd24;
    localparam logic [4:0] F_AAS  = 5'd25;
    localparam logic [4:0] F_DAA  = 5'd26;
    localparam logic [4:0] F_DAS  = 5'd27;
    localparam logic [4:0] F_AAM  = 5'd28;
    localparam logic [4:0] F_AAD  = 5'd29;
    localparam logic [4:0] F_CBW  = 5'd30;
    localparam logic [4:0] F_CWD  = 5'd31;

    localparam int FL_C = 0;
    localparam int FL_P = 1;
    localparam int FL_A = 2;
    localparam int FL_Z = 3;
    localparam int FL_S = 4;
    localparam int FL_O = 5;

    localparam int DIV_BITS     = 16;
    localparam int DIV_STEPS_DEF = 2;

    localparam logic [1:0] M_ALU = 2'd0;
    localparam logic [1:0] M_MUL = 2'd1;
    localparam logic [1:0] M_DIV = 2'd2;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] dq;
        logic [15:0] dvs;
    } t_div;

    typedef struct packed {
        logic [1:0]  mode;
        logic        imul_idiv;
        logic        wide;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] res;
        logic [15:0] hi;
        logic [5:0]  f;
        logic        wb;
        logic [31:0] prod;
        logic        dneg;
        logic        bneg;
        logic        pre_err;
    } t_side;

    function automatic logic [5:0] set_szp(logic [5:0] f, logic [15:0] v, logic wide);
        logic [5:0] g;
        g = f;
        g[FL_Z] = wide ? (v == 16'd0) : (v[7:0] == 8'd0);
        g[FL_S] = wide ? v[15] : v[7];
        g[FL_P] = ~^v[7:0];
        return g;
    endfunction

endpackage

// File: hdl/x86a_div_stage.sv
// ----------------------------------------------------------------------------
// x86a_div_stage
// Registered restoring-division stage: STEPS quotient bits per cycle while i_en is high.
// ----------------------------------------------------------------------------
module x86a_div_stage #(
    parameter int STEPS = x86a_pkg::DIV_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  x86a_pkg::t_div i_div,
    output x86a_pkg::t_div o_div
);
    import x86a_pkg::*;

    t_div        n_div;
    t_div        r_div;

    always_comb begin
        logic [16:0] t;
        n_div = i_div;
        for (int k = 0; k < STEPS; k++) begin
            t = {n_div.rem, n_div.dq[15]};
            if (t >= {1'b0, n_div.dvs}) begin
                t = t - {1'b0, n_div.dvs};
                n_div.rem = t[15:0];
                n_div.dq  = {n_div.dq[14:0], 1'b1};
            end else begin
                n_div.rem = t[15:0];
                n_div.dq  = {n_div.dq[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;
endmodule

// File: hdl/x86_16_alu_with_flags.sv
// ----------------------------------------------------------------------------
// x86_16_alu_with_flags
// Every operation passes the input register, the stage-1 register, the divider
// stages and the output register; one operation per cycle while not stalled.
// The divider's restoring stages, DIV_STEPS quotient bits each, set the depth.
// A stall on the output freezes the whole pipeline. Synchronous reset clears
// the valid bits only.
// ----------------------------------------------------------------------------
module x86_16_alu_with_flags #(
    parameter int DIV_STEPS = x86a_pkg::DIV_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_func,
    input  logic        i_wide,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [15:0] i_extend_word,
    input  logic [5:0]  i_flags_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result,
    output logic [15:0] o_result_high,
    output logic [5:0]  o_flags_out,
    output logic        o_divide_error,
    output logic        o_writes_back
);
    import x86a_pkg::*;

    localparam int NDIV = DIV_BITS / DIV_STEPS;

    logic        en;
    logic [NDIV+1:0] r_vld;
    logic        r_out_vld;

    logic [4:0]  r0_func;
    logic        r0_wide;
    logic [15:0] r0_ax, r0_b_raw, r0_dx;
    logic [5:0]  r0_f;

    t_side       n1_side;
    t_div        n1_div;
    t_side       r_side [0:NDIV];
    t_div        s_div  [0:NDIV];
    t_div        r1_div;

    logic [15:0] n_res_o, n_hi_o;
    logic [5:0]  n_fo_o;
    logic        n_err_o, n_wb_o;

    logic [15:0] r_res, r_hi;
    logic [5:0]  r_fo;
    logic        r_err, r_wb;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NDIV:0], i_valid};
            r_out_vld <= r_vld[NDIV+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_func  <= i_func;
            r0_wide  <= i_wide;
            r0_ax    <= i_operand_a;
            r0_b_raw <= i_operand_b;
            r0_dx    <= i_extend_word;
            r0_f     <= i_flags_in;
        end
    end

    // stage 1: ALU, shifts, adjusts, multiplier, divide setup
    always_comb begin
        logic [15:0] a, b, x, y, as_res, ovec, res;
        logic [16:0] s17;
        logic        cin, is_sub, cf, c_as, o_as, a_as;
        logic [5:0]  f, f_as;
        logic [4:0]  cnt, cm1, r17, r9, rr;
        logic [31:0] sh32, rw;
        logic [15:0] shr_t, rb, rol_r, ror_r;
        logic signed [31:0] sa, sar_t, sar_v;
        logic [16:0] v17, rcv;
        logic [33:0] rc34;
        logic [8:0]  v9;
        logic [17:0] rc18;
        logic        sc;
        logic signed [16:0] ma, mb;
        logic signed [33:0] pr;
        logic [7:0]  al, ah;
        logic        adj, hiadj, loadj;
        logic [17:0] q10;
        logic [7:0]  aq;
        logic [31:0] dd, dmag, dsh;
        logic [15:0] bmag, dvs, ax_neg;
        logic [7:0]  b8n;
        logic        dneg, bneg, uovf, idv;

        a  = r0_wide ? r0_ax : {8'd0, r0_ax[7:0]};
        b  = r0_wide ? r0_b_raw : {8'd0, r0_b_raw[7:0]};
        f  = r0_f;
        cf = f[FL_C];
        al = r0_ax[7:0];
        ah = r0_ax[15:8];
        sc    = 1'b0;
        adj   = 1'b0;
        hiadj = 1'b0;
        loadj = 1'b0;
        q10   = '0;
        aq    = '0;
        rc34  = '0;
        rc18  = '0;
        rcv   = '0;

        // add / subtract family
        x = a;
        y = b;
        cin = 1'b0;
        is_sub = 1'b0;
        case (r0_func)
            F_ADC:        cin = cf;
            F_SUB, F_CMP: is_sub = 1'b1;
            F_SBB: begin
                is_sub = 1'b1;
                cin    = cf;
            end
            F_INC:        y = 16'd1;
            F_DEC: begin
                is_sub = 1'b1;
                y      = 16'd1;
            end
            F_NEG: begin
                is_sub = 1'b1;
                x      = 16'd0;
                y      = a;
            end
            default: ;
        endcase
        s17 = is_sub ? ({1'b0, x} - {1'b0, y} - {16'd0, cin})
                     : ({1'b0, x} + {1'b0, y} + {16'd0, cin});
        as_res = r0_wide ? s17[15:0] : {8'd0, s17[7:0]};
        c_as = r0_wide ? s17[16] : s17[8];
        a_as = x[4] ^ y[4] ^ s17[4];
        ovec = is_sub ? ((x ^ y) & (x ^ s17[15:0])) : ((x ^ s17[15:0]) & (y ^ s17[15:0]));
        o_as = r0_wide ? ovec[15] : ovec[7];
        f_as = set_szp(f, as_res, r0_wide);
        f_as[FL_C] = c_as;
        f_as[FL_A] = a_as;
        f_as[FL_O] = o_as;

        // shifts and rotates
        cnt   = r0_b_raw[4:0];
        cm1   = cnt - 5'd1;
        sh32  = {16'd0, a} << cnt;
        shr_t = a >> cm1;
        sa    = r0_wide ? {{16{a[15]}}, a} : {{24{a[7]}}, a[7:0]};
        sar_t = sa >>> cm1;
        sar_v = sar_t >>> 1;
        rw    = {a, a} << cnt[3:0];
        rb    = {a[7:0], a[7:0]} << cnt[2:0];
        rol_r = r0_wide ? rw[31:16] : {8'd0, rb[15:8]};
        rw    = {a, a} >> cnt[3:0];
        rb    = {a[7:0], a[7:0]} >> cnt[2:0];
        ror_r = r0_wide ? rw[15:0] : {8'd0, rb[7:0]};
        r17   = (cnt >= 5'd17) ? cnt - 5'd17 : cnt;
        r9    = (cnt >= 5'd27) ? cnt - 5'd27 : (cnt >= 5'd18) ? cnt - 5'd18 :
                (cnt >= 5'd9) ? cnt - 5'd9 : cnt;
        v17   = {cf, a};
        v9    = {cf, a[7:0]};
        rr    = r0_wide ? r17 : r9;

        // multiplier
        idv = (r0_func == F_IMUL) || (r0_func == F_IDIV);
        ma  = (r0_func == F_IMUL) ? (r0_wide ? {a[15], a} : {{9{a[7]}}, a[7:0]}) : {1'b0, a};
        mb  = (r0_func == F_IMUL) ? (r0_wide ? {b[15], b} : {{9{b[7]}}, b[7:0]}) : {1'b0, b};
        pr  = ma * mb;

        // divide setup
        dd     = r0_wide ? {r0_dx, r0_ax} : {16'd0, r0_ax};
        dneg   = idv && (r0_wide ? r0_dx[15] : r0_ax[15]);
        bneg   = idv && (r0_wide ? b[15] : b[7]);
        ax_neg = 16'd0 - r0_ax;
        b8n    = 8'd0 - b[7:0];
        if (r0_wide) begin
            dmag = dneg ? 32'd0 - dd : dd;
            bmag = bneg ? 16'd0 - b : b;
            uovf = dmag[31:16] >= bmag;
            dsh  = dmag;
            dvs  = bmag;
        end else begin
            dmag = {16'd0, dneg ? ax_neg : r0_ax};
            bmag = {8'd0, bneg ? b8n : b[7:0]};
            uovf = dmag[15:8] >= bmag[7:0];
            dsh  = {8'd0, dmag[15:0], 8'd0};
            dvs  = {bmag[7:0], 8'd0};
        end
        n1_div.rem = dsh[31:16];
        n1_div.dq  = dsh[15:0];
        n1_div.dvs = dvs;

        res = a;
        n1_side.hi   = 16'd0;
        n1_side.wb   = 1'b1;
        n1_side.mode = M_ALU;
        case (r0_func)
            F_ADD, F_ADC, F_SUB, F_SBB, F_NEG: begin
                res = as_res;
                f   = f_as;
            end
            F_CMP: begin
                f = f_as;
                n1_side.wb = 1'b0;
            end
            F_INC, F_DEC: begin
                res = as_res;
                f   = f_as;
                f[FL_C] = cf;
            end
            F_AND, F_OR, F_XOR, F_TEST: begin
                res = (r0_func == F_OR) ? (a | b) : (r0_func == F_XOR) ? (a ^ b) : (a & b);
                f = set_szp(f, res, r0_wide);
                f[FL_C] = 1'b0;
                f[FL_O] = 1'b0;
                f[FL_A] = 1'b0;
                if (r0_func == F_TEST) begin
                    res = a;
                    n1_side.wb = 1'b0;
                end
            end
            F_NOT: res = ~a & (r0_wide ? 16'hFFFF : 16'h00FF);
            F_SHL, F_SHR, F_SAR: begin
                if (cnt != 5'd0) begin
                    if (r0_func == F_SHL) begin
                        res = r0_wide ? sh32[15:0] : {8'd0, sh32[7:0]};
                        sc  = r0_wide ? sh32[16] : sh32[8];
                    end else if (r0_func == F_SHR) begin
                        res = shr_t >> 1;
                        sc  = shr_t[0];
                    end else begin
                        res = r0_wide ? sar_v[15:0] : {8'd0, sar_v[7:0]};
                        sc  = sar_t[0];
                    end
                    f[FL_C] = sc;
                    f[FL_O] = r0_wide ? (res[15] ^ a[15]) : (res[7] ^ a[7]);
                    f = set_szp(f, res, r0_wide);
                end
            end
            F_ROL, F_ROR: begin
                if (cnt != 5'd0) begin
                    res = (r0_func == F_ROL) ? rol_r : ror_r;
                    f[FL_C] = (r0_func == F_ROL) ? res[0] : (r0_wide ? res[15] : res[7]);
                    f[FL_O] = r0_wide ? (res[15] ^ a[15]) : (res[7] ^ a[7]);
                end
            end
            F_RCL, F_RCR: begin
                if (r0_wide) begin
                    rc34 = (r0_func == F_RCL) ? ({v17, v17} << r17) : ({v17, v17} >> r17);
                    rcv  = (r0_func == F_RCL) ? rc34[33:17] : rc34[16:0];
                end else begin
                    rc18 = (r0_func == F_RCL) ? ({v9, v9} << r9) : ({v9, v9} >> r9);
                    rcv  = {8'd0, (r0_func == F_RCL) ? rc18[17:9] : rc18[8:0]};
                end
                if (cnt != 5'd0 && rr != 5'd0) begin
                    res = r0_wide ? rcv[15:0] : {8'd0, rcv[7:0]};
                    f[FL_C] = r0_wide ? rcv[16] : rcv[8];
                    f[FL_O] = r0_wide ? (res[15] ^ a[15]) : (res[7] ^ a[7]);
                end
            end
            F_MUL, F_IMUL: n1_side.mode = M_MUL;
            F_DIV, F_IDIV: n1_side.mode = M_DIV;
            F_AAA, F_AAS: begin
                adj = (al[3:0] > 4'd9) || f[FL_A];
                if (adj) begin
                    al = (r0_func == F_AAA) ? al + 8'd6 : al - 8'd6;
                    ah = (r0_func == F_AAA) ? ah + 8'd1 : ah - 8'd1;
                end
                f[FL_C] = adj;
                f[FL_A] = adj;
                res = {ah, 4'd0, al[3:0]};
            end
            F_DAA, F_DAS: begin
                hiadj = (al > 8'h99) || cf;
                loadj = (al[3:0] > 4'd9) || f[FL_A];
                if (loadj) al = (r0_func == F_DAA) ? al + 8'h06 : al - 8'h06;
                if (hiadj) al = (r0_func == F_DAA) ? al + 8'h60 : al - 8'h60;
                f[FL_A] = loadj;
                f[FL_C] = hiadj;
                f = set_szp(f, {8'd0, al}, 1'b0);
                res = {ah, al};
            end
            F_AAM: begin
                q10 = {10'd0, al} * 18'd205;
                aq  = {3'd0, q10[15:11]};
                al  = al - ((aq << 3) + (aq << 1));
                f   = set_szp(f, {8'd0, al}, 1'b0);
                res = {aq, al};
            end
            F_AAD: begin
                al  = (ah << 3) + (ah << 1) + al;
                f   = set_szp(f, {8'd0, al}, 1'b0);
                res = {8'd0, al};
            end
            F_CBW: res = {{8{al[7]}}, al};
            default: begin
                res = r0_ax;
                n1_side.hi = {16{r0_ax[15]}};
            end
        endcase

        n1_side.imul_idiv = idv;
        n1_side.wide      = r0_wide;
        n1_side.ax        = r0_ax;
        n1_side.dx        = r0_dx;
        n1_side.res       = res;
        n1_side.f         = f;
        n1_side.prod      = pr[31:0];
        n1_side.dneg      = dneg;
        n1_side.bneg      = bneg;
        n1_side.pre_err   = (b == 16'd0) || uovf;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n1_side;
            r1_div    <= n1_div;
            for (int k = 1; k <= NDIV; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign s_div[0] = r1_div;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        x86a_div_stage #(
            .STEPS (DIV_STEPS)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (s_div[g]),
            .o_div (s_div[g+1])
        );
    end

    // final stage: multiply flags, divide sign fix and selection
    always_comb begin
        t_side       sd;
        t_div        dv;
        logic [15:0] n_res, n_hi, q, r, qs, rs;
        logic [5:0]  n_fo;
        logic        n_err, n_wb, mf, lim;
        sd = r_side[NDIV];
        dv = s_div[NDIV];
        n_res = sd.res;
        n_hi  = sd.hi;
        n_fo  = sd.f;
        n_wb  = sd.wb;
        n_err = 1'b0;
        mf    = 1'b0;
        lim   = 1'b0;
        q = dv.dq;
        r = dv.rem;
        qs = 16'd0 - q;
        rs = 16'd0 - r;
        case (sd.mode)
            M_MUL: begin
                if (sd.wide) begin
                    mf = sd.imul_idiv ? (sd.prod[31:16] != {16{sd.prod[15]}})
                                      : (sd.prod[31:16] != 16'd0);
                    n_res = sd.prod[15:0];
                    n_hi  = sd.prod[31:16];
                end else begin
                    mf = sd.imul_idiv ? (sd.prod[15:8] != {8{sd.prod[7]}})
                                      : (sd.prod[15:8] != 8'd0);
                    n_res = sd.prod[15:0];
                end
                n_fo[FL_C] = mf;
                n_fo[FL_O] = mf;
            end
            M_DIV: begin
                lim   = sd.imul_idiv && (sd.wide ? q[15] : q[7]);
                n_err = sd.pre_err || lim;
                if (n_err) begin
                    n_res = sd.ax;
                    n_hi  = sd.wide ? sd.dx : 16'd0;
                    n_wb  = 1'b0;
                end else if (sd.wide) begin
                    n_res = (sd.dneg ^ sd.bneg) ? qs : q;
                    n_hi  = sd.dneg ? rs : r;
                end else begin
                    n_res = {sd.dneg ? (8'd0 - r[15:8]) : r[15:8],
                             (sd.dneg ^ sd.bneg) ? qs[7:0] : q[7:0]};
                    n_hi  = 16'd0;
                end
            end
            default: ;
        endcase
        n_res_o = n_res;
        n_hi_o  = n_hi;
        n_fo_o  = n_fo;
        n_err_o = n_err;
        n_wb_o  = n_wb;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res_o;
            r_hi  <= n_hi_o;
            r_fo  <= n_fo_o;
            r_err <= n_err_o;
            r_wb  <= n_wb_o;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result       = r_res;
    assign o_result_high  = r_hi;
    assign o_flags_out    = r_fo;
    assign o_divide_error = r_err;
    assign o_writes_back  = r_wb;
endmodule

// File: bench/x86_16_alu_with_flags_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16_alu_with_flags_test
// Drives byte and word ALU operations with random flags and random idle on
// both sides, predicts result, high result, flags, divide error and
// write-back for every transfer, and checks each output in order.
// ----------------------------------------------------------------------------
module x86_16_alu_with_flags_test;
    import x86a_pkg::*;

    typedef struct {
        logic [4:0]  func;
        logic        wide;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] dx;
        logic [5:0]  fl;
    } t_alu_op;

    typedef struct {
        logic [15:0] res;
        logic [15:0] hi;
        logic [5:0]  fl;
        logic        err;
        logic        wb;
    } t_alu_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [4:0]  i_func;
    logic        i_wide;
    logic [15:0] i_operand_a;
    logic [15:0] i_operand_b;
    logic [15:0] i_extend_word;
    logic [5:0]  i_flags_in;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_result;
    logic [15:0] o_result_high;
    logic [5:0]  o_flags_out;
    logic        o_divide_error;
    logic        o_writes_back;

    t_alu_res expected_q[$];
    int       n_fail = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       cycle_count = 0;
    bit       idle_enable = 1'b1;

    x86_16_alu_with_flags dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [5:0] put_szp(logic [5:0] f, logic [31:0] v, logic wide);
        logic [5:0] g;
        g = f;
        g[FL_Z] = wide ? (v[15:0] == 16'd0) : (v[7:0] == 8'd0);
        g[FL_S] = wide ? v[15] : v[7];
        g[FL_P] = ~^v[7:0];
        return g;
    endfunction

    function automatic t_alu_res compute_alu(t_alu_op op);
        t_alu_res    r;
        logic [31:0] mask, msb, a, b, ax, dx, s, t, v, nmask, p, lo, h, dd, q, rm;
        logic [31:0] dmsb, dmask, dmag, bmag, al, ah, old;
        logic [5:0]  f;
        int          bits, cnt, rot, n;
        logic        cf, c, flag, dneg, bneg, adj, hiadj, loadj;

        bits = op.wide ? 16 : 8;
        mask = op.wide ? 32'hFFFF : 32'hFF;
        msb = op.wide ? 32'h8000 : 32'h80;
        ax = {16'd0, op.a};
        a = ax & mask;
        b = {16'd0, op.b} & mask;
        dx = {16'd0, op.dx};
        f = op.fl;
        cf = f[FL_C];
        r.res = a[15:0];
        r.hi = 16'd0;
        r.err = 1'b0;
        r.wb = 1'b1;
        cnt = int'(b[4:0]);
        al = ax & 32'hFF;
        ah = (ax >> 8) & 32'hFF;
        case (op.func)
            F_ADD, F_ADC, F_INC: begin
                t = (op.func == F_INC) ? 32'd1 : b;
                s = a + t + ((op.func == F_ADC) ? {31'd0, cf} : 32'd0);
                f = put_szp(f, s, op.wide);
                if (op.func != F_INC) f[FL_C] = (s & (mask + 32'd1)) != 32'd0;
                f[FL_A] = ((a ^ t ^ s) & 32'h10) != 32'd0;
                f[FL_O] = ((a ^ s) & (t ^ s) & msb) != 32'd0;
                r.res = 16'(s & mask);
            end
            F_SUB, F_SBB, F_CMP, F_DEC, F_NEG: begin
                v = (op.func == F_NEG) ? 32'd0 : a;
                t = (op.func == F_DEC) ? 32'd1 : (op.func == F_NEG) ? a : b;
                s = v - t - ((op.func == F_SBB) ? {31'd0, cf} : 32'd0);
                f = put_szp(f, s, op.wide);
                if (op.func != F_DEC) f[FL_C] = (s & (mask + 32'd1)) != 32'd0;
                f[FL_A] = ((v ^ t ^ s) & 32'h10) != 32'd0;
                f[FL_O] = ((v ^ t) & (v ^ s) & msb) != 32'd0;
                r.res = (op.func == F_CMP) ? a[15:0] : 16'(s & mask);
                if (op.func == F_CMP) r.wb = 1'b0;
            end
            F_AND, F_OR, F_XOR, F_TEST: begin
                s = (op.func == F_OR) ? (a | b) : (op.func == F_XOR) ? (a ^ b) : (a & b);
                f = put_szp(f, s, op.wide);
                f[FL_C] = 1'b0;
                f[FL_O] = 1'b0;
                f[FL_A] = 1'b0;
                r.res = (op.func == F_TEST) ? a[15:0] : s[15:0];
                if (op.func == F_TEST) r.wb = 1'b0;
            end
            F_NOT: r.res = 16'(~a & mask);
            F_SHL, F_SHR, F_SAR: if (cnt != 0) begin
                if (op.func == F_SHL) begin
                    t = a << cnt;
                    c = t[bits];
                    s = t & mask;
                end else if (op.func == F_SHR) begin
                    c = a[cnt - 1];
                    s = a >> cnt;
                end else begin
                    t = ((a & msb) != 32'd0) ? (a | ~mask) : a;
                    c = t[cnt - 1];
                    s = 32'($signed(t) >>> cnt) & mask;
                end
                f[FL_C] = c;
                f[FL_O] = ((s ^ a) & msb) != 32'd0;
                f = put_szp(f, s, op.wide);
                r.res = s[15:0];
            end
            F_ROL, F_ROR: if (cnt != 0) begin
                rot = cnt % bits;
                s = a;
                if (rot != 0) begin
                    if (op.func == F_ROL) s = ((a << rot) | (a >> (bits - rot))) & mask;
                    else s = ((a >> rot) | (a << (bits - rot))) & mask;
                end
                f[FL_C] = (op.func == F_ROL) ? s[0] : ((s & msb) != 32'd0);
                f[FL_O] = ((s ^ a) & msb) != 32'd0;
                r.res = s[15:0];
            end
            F_RCL, F_RCR: if (cnt != 0) begin
                n = bits + 1;
                nmask = (mask << 1) | 32'd1;
                v = a | ({31'd0, cf} << bits);
                rot = cnt % n;
                if (rot != 0) begin
                    if (op.func == F_RCL) v = ((v << rot) | (v >> (n - rot))) & nmask;
                    else v = ((v >> rot) | (v << (n - rot))) & nmask;
                    s = v & mask;
                    f[FL_C] = v[bits];
                    f[FL_O] = ((s ^ a) & msb) != 32'd0;
                    r.res = s[15:0];
                end
            end
            F_MUL, F_IMUL: begin
                if (op.func == F_MUL) p = a * b;
                else p = 32'($signed((a ^ msb) - msb) * $signed((b ^ msb) - msb));
                lo = p & mask;
                h = (p >> bits) & mask;
                flag = (op.func == F_MUL) ? (h != 32'd0)
                                          : (h != (((lo & msb) != 32'd0) ? mask : 32'd0));
                f[FL_C] = flag;
                f[FL_O] = flag;
                if (op.wide) begin
                    r.res = lo[15:0];
                    r.hi = h[15:0];
                end else begin
                    r.res = p[15:0];
                end
            end
            F_DIV, F_IDIV: begin
                dd = op.wide ? ((dx << 16) | ax) : ax;
                q = 32'd0;
                rm = 32'd0;
                if (b == 32'd0) begin
                    r.err = 1'b1;
                end else if (op.func == F_DIV) begin
                    q = dd / b;
                    rm = dd % b;
                    if (q > mask) r.err = 1'b1;
                end else begin
                    dmsb = op.wide ? 32'h8000_0000 : 32'h8000;
                    dmask = op.wide ? 32'hFFFF_FFFF : 32'hFFFF;
                    dneg = (dd & dmsb) != 32'd0;
                    bneg = (b & msb) != 32'd0;
                    dmag = dneg ? ((32'd0 - dd) & dmask) : dd;
                    bmag = bneg ? ((32'd0 - b) & mask) : b;
                    q = dmag / bmag;
                    rm = dmag % bmag;
                    if (q > msb - 32'd1) r.err = 1'b1;
                    if (dneg != bneg) q = (32'd0 - q) & mask;
                    if (dneg) rm = (32'd0 - rm) & mask;
                end
                if (r.err) begin
                    r.res = ax[15:0];
                    r.hi = op.wide ? dx[15:0] : 16'd0;
                    r.wb = 1'b0;
                end else if (op.wide) begin
                    r.res = q[15:0];
                    r.hi = rm[15:0];
                end else begin
                    r.res = {rm[7:0], q[7:0]};
                end
            end
            F_AAA, F_AAS: begin
                adj = (al & 32'hF) > 32'd9 || f[FL_A];
                if (adj) begin
                    if (op.func == F_AAA) begin
                        al = (al + 32'd6) & 32'hFF;
                        ah = (ah + 32'd1) & 32'hFF;
                    end else begin
                        al = (al - 32'd6) & 32'hFF;
                        ah = (ah - 32'd1) & 32'hFF;
                    end
                end
                f[FL_C] = adj;
                f[FL_A] = adj;
                r.res = {ah[7:0], 4'd0, al[3:0]};
            end
            F_DAA, F_DAS: begin
                old = al;
                hiadj = old > 32'h99 || cf;
                loadj = (al & 32'hF) > 32'd9 || f[FL_A];
                if (loadj) al = (op.func == F_DAA) ? al + 32'd6 : al - 32'd6;
                if (hiadj) al = (op.func == F_DAA) ? al + 32'h60 : al - 32'h60;
                al = al & 32'hFF;
                f[FL_A] = loadj;
                f[FL_C] = hiadj;
                f = put_szp(f, al, 1'b0);
                r.res = {ah[7:0], al[7:0]};
            end
            F_AAM: begin
                ah = al / 32'd10;
                al = al % 32'd10;
                f = put_szp(f, al, 1'b0);
                r.res = {ah[7:0], al[7:0]};
            end
            F_AAD: begin
                al = (ah * 32'd10 + al) & 32'hFF;
                f = put_szp(f, al, 1'b0);
                r.res = al[15:0];
            end
            F_CBW: r.res = al[7] ? {8'hFF, al[7:0]} : {8'h00, al[7:0]};
            default: begin
                r.res = ax[15:0];
                r.hi = ax[15] ? 16'hFFFF : 16'h0000;
            end
        endcase
        r.fl = f;
        return r;
    endfunction

    task automatic send_op(logic [4:0] func, logic wide, logic [15:0] a, logic [15:0] b,
                           logic [15:0] dx, logic [5:0] fl);
        t_alu_op op;
        int      gap;
        op = '{func, wide, a, b, dx, fl};
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = int'($urandom_range(1, 7));
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func = func;
        i_wide = wide;
        i_operand_a = a;
        i_operand_b = b;
        i_extend_word = dx;
        i_flags_in = fl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(compute_alu(op));
        n_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_alu_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: result=%h", o_result);
                n_fail++;
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (o_result !== e.res) begin
                    $error("result exp %h got %h", e.res, o_result);
                    n_fail++;
                end
                if (o_result_high !== e.hi) begin
                    $error("result_high exp %h got %h", e.hi, o_result_high);
                    n_fail++;
                end
                if (o_flags_out !== e.fl) begin
                    $error("flags_out exp %h got %h", e.fl, o_flags_out);
                    n_fail++;
                end
                if (o_divide_error !== e.err) begin
                    $error("divide_error exp %b got %b", e.err, o_divide_error);
                    n_fail++;
                end
                if (o_writes_back !== e.wb) begin
                    $error("writes_back exp %b got %b", e.wb, o_writes_back);
                    n_fail++;
                end
            end
        end
    end

    // output idle: random bursts with ready low
    always begin
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        logic [4:0] fn;
        send_op(F_ADD, 1'b0, 16'h00FF, 16'h0001, 16'h0, 6'h00);
        send_op(F_ADD, 1'b1, 16'h7FFF, 16'h0001, 16'h0, 6'h3F);
        send_op(F_SBB, 1'b1, 16'h0000, 16'hFFFF, 16'h0, 6'h01);
        send_op(F_NEG, 1'b1, 16'h0000, 16'h0, 16'h0, 6'h01);
        send_op(F_SHL, 1'b0, 16'h0081, 16'h0009, 16'h0, 6'h00);
        send_op(F_SAR, 1'b1, 16'h8000, 16'h001F, 16'h0, 6'h00);
        send_op(F_SHR, 1'b1, 16'hFFFF, 16'h0020, 16'h0, 6'h15);
        send_op(F_RCL, 1'b0, 16'h0055, 16'h0009, 16'h0, 6'h01);
        send_op(F_RCR, 1'b1, 16'h1234, 16'h0011, 16'h0, 6'h01);
        send_op(F_ROL, 1'b0, 16'h0081, 16'h0010, 16'h0, 6'h00);
        send_op(F_MUL, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0, 6'h00);
        send_op(F_IMUL, 1'b0, 16'h0080, 16'h00FF, 16'h0, 6'h00);
        send_op(F_DIV, 1'b1, 16'h1234, 16'h0000, 16'h5678, 6'h2A);
        send_op(F_DIV, 1'b0, 16'hFFFF, 16'h0001, 16'h0, 6'h00);
        send_op(F_IDIV, 1'b1, 16'h0000, 16'hFFFF, 16'h8000, 6'h00);
        send_op(F_IDIV, 1'b0, 16'hFF81, 16'h0001, 16'h0, 6'h00);
        send_op(F_DAA, 1'b0, 16'h009A, 16'h0, 16'h0, 6'h05);
        send_op(F_DAS, 1'b0, 16'h0000, 16'h0, 16'h0, 6'h01);
        send_op(F_AAA, 1'b0, 16'h00FF, 16'h0, 16'h0, 6'h00);
        for (int i = 0; i < 32; i++) begin
            fn = i[4:0];
            if (fn inside {F_CMP, F_TEST, F_INC, F_DEC, F_NOT, F_AAS, F_AAM, F_AAD,
                           F_CBW, F_CWD, F_AND, F_OR, F_XOR, F_ADC, F_SUB, F_ROR}) begin
                send_op(fn, i[0], 16'hFF80, 16'h8081, 16'hFFFF, 6'h3F);
            end
        end
    endtask

    task automatic test_random(int count);
        logic [15:0] a, b;
        for (int i = 0; i < count; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case ($urandom_range(0, 5))
                0: b = 16'($urandom_range(0, 40));
                1: b = 16'($urandom_range(0, 3));
                2: a = {$urandom_range(0, 1) ? 8'hFF : 8'h00, a[7:0]};
                default: ;
            endcase
            send_op(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), a, b,
                    16'($urandom), 6'($urandom_range(0, 63)));
        end
    endtask

    task automatic test_divide(int count);
        logic [15:0] b;
        for (int i = 0; i < count; i++) begin
            b = $urandom_range(1, 3) == 1 ? 16'($urandom) : 16'($urandom_range(1, 300));
            send_op($urandom_range(0, 1) ? F_DIV : F_IDIV, 1'($urandom_range(0, 1)),
                    16'($urandom), b,
                    $urandom_range(0, 1) ? 16'($urandom_range(0, 200)) : 16'($urandom),
                    6'($urandom_range(0, 63)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = F_ADD;
        i_wide = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        i_extend_word = '0;
        i_flags_in = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        wait_drained();
        test_random(900);
        test_divide(300);
        idle_enable = 1'b0;
        test_random(200);
        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d ALU operations (all 32 codes, byte and word), checked %0d results.",
                 n_sent, n_checked);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/x86a_pkg.sv
hdl/x86a_div_stage.sv
hdl/x86_16_alu_with_flags.sv
bench/x86_16_alu_with_flags_test.sv
